@@ src/acm_pkg.sv @@
// acm_pkg: shared types, constants and ring-pointer helpers for the CDC ACM
// control and receive FIFO block. No dependencies.

package acm_pkg;

    // Receive ring buffer sizing
    localparam int BUFFER_DEPTH = 256;
    localparam int HIGH_MARK    = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);

    // APB register map
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;
    localparam int CTRL_IF_W      = 4;
    localparam bit REG_CTRL_IF_WD = 1'b0;   // word index of control_interface

    // Operation codes
    localparam logic [2:0] OP_SETUP = 3'd0;
    localparam logic [2:0] OP_CDATA = 3'd1;
    localparam logic [2:0] OP_BULK  = 3'd2;
    localparam logic [2:0] OP_POP   = 3'd3;
    localparam logic [2:0] OP_PEEK  = 3'd4;

    // Class request signatures {bmRequestType, bRequest}
    localparam logic [15:0] SIG_SET_CODING = 16'h2120;
    localparam logic [15:0] SIG_SET_STATE  = 16'h2122;
    localparam logic [15:0] SIG_GET_CODING = 16'hA121;
    localparam logic [31:0] TOUCH_BAUD     = 32'd1200;

    // Reply kinds
    localparam logic [1:0] REPLY_NONE   = 2'd0;
    localparam logic [1:0] REPLY_STATUS = 2'd1;
    localparam logic [1:0] REPLY_CODING = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [7:0]  value_low;
        logic [7:0]  index_low;
        logic [7:0]  target;
        logic [31:0] rate;
        logic [7:0]  char_format;
        logic [7:0]  parity_code;
        logic [7:0]  data_bit_count;
        logic [7:0]  data_byte;
        logic        last_in_packet;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  reply_kind;
        logic [31:0] reply_rate;
        logic [7:0]  reply_char_format;
        logic [7:0]  reply_parity;
        logic [7:0]  reply_data_bits;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        halt_rx;
        logic        resume_rx;
        logic        enter_bootloader;
        logic [7:0]  fill_count;
    } t_out_item;

    // Control-request side result
    typedef struct packed {
        logic        accepted;
        logic [1:0]  reply_kind;
        logic [31:0] reply_rate;
        logic [7:0]  reply_char_format;
        logic [7:0]  reply_parity;
        logic [7:0]  reply_data_bits;
        logic        enter_bootloader;
    } t_ctrl_res;

    // Receive FIFO side result
    typedef struct packed {
        logic        accepted;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        halt_rx;
        logic        resume_rx;
        logic [7:0]  fill_count;
    } t_fifo_res;

    // Advance a ring pointer by one
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // (a - b) mod BUFFER_DEPTH
    function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] a,
                                                   input logic [PTR_W-1:0] b);
        logic [PTR_W:0] wide;
        wide = {1'b0, a} + ((a >= b) ? '0 : (PTR_W+1)'(BUFFER_DEPTH)) - {1'b0, b};
        ring_dist = wide[PTR_W-1:0];
    endfunction

endpackage

@@ src/acm_ctrl.sv @@
// acm_ctrl: class request decode and line coding storage.
// Depends on acm_pkg.

module acm_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  acm_pkg::t_in_item                   i_item,
    input  logic [acm_pkg::CTRL_IF_W-1:0]       i_ctrl_if,
    output acm_pkg::t_ctrl_res                  o_res
);
    import acm_pkg::*;

    logic [31:0] r_baud;
    logic [7:0]  r_stop;
    logic [7:0]  r_parity;
    logic [7:0]  r_dbits;
    logic        r_pending;

    logic [15:0] sig;
    logic        setup_hit;
    logic        data_hit;
    logic        touch;

    assign sig       = {i_item.request_type, i_item.request_code};
    assign setup_hit = (i_item.operation == OP_SETUP) &&
                       (i_item.index_low == 8'(i_ctrl_if));
    assign data_hit  = (i_item.operation == OP_CDATA) &&
                       (i_item.target == 8'(i_ctrl_if)) && r_pending;
    assign touch     = (r_baud == TOUCH_BAUD);

    always_comb begin
        o_res = '0;
        if (setup_hit) begin
            unique case (sig)
                SIG_SET_CODING: begin
                    o_res.accepted = 1'b1;
                end
                SIG_SET_STATE: begin
                    o_res.accepted         = 1'b1;
                    o_res.reply_kind       = REPLY_STATUS;
                    o_res.enter_bootloader = (i_item.value_low == 8'd0) && touch;
                end
                SIG_GET_CODING: begin
                    o_res.accepted          = 1'b1;
                    o_res.reply_kind        = REPLY_CODING;
                    o_res.reply_rate        = r_baud;
                    o_res.reply_char_format = r_stop;
                    o_res.reply_parity      = r_parity;
                    o_res.reply_data_bits   = r_dbits;
                end
                default: ;
            endcase
        end else if (data_hit) begin
            o_res.accepted         = 1'b1;
            o_res.reply_kind       = REPLY_STATUS;
            o_res.enter_bootloader = (i_item.rate == 32'd0) && touch;
        end
    end

    // Line state only feeds the touch check, which uses the incoming value,
    // so it is not kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baud    <= '0;
            r_stop    <= '0;
            r_parity  <= '0;
            r_dbits   <= '0;
            r_pending <= 1'b0;
        end else if (i_fire) begin
            if (setup_hit && sig == SIG_SET_CODING) begin
                r_pending <= 1'b1;
            end
            if (data_hit) begin
                r_baud   <= i_item.rate;
                r_stop   <= i_item.char_format;
                r_parity <= i_item.parity_code;
                r_dbits  <= i_item.data_bit_count;
            end
        end
    end

endmodule

@@ src/acm_rxfifo.sv @@
// acm_rxfifo: bulk OUT receive ring buffer with halt/resume flow control.
// Depends on acm_pkg.

module acm_rxfifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  acm_pkg::t_in_item  i_item,
    output acm_pkg::t_fifo_res o_res
);
    import acm_pkg::*;

    logic [7:0]       mem [BUFFER_DEPTH];
    logic [7:0]       r_mem_q;
    logic             r_byp;
    logic [7:0]       r_byp_data;
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;

    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic             empty;
    logic             is_bulk;
    logic             is_pop;
    logic             is_look;
    logic             wr_en;
    logic [7:0]       head;

    assign wp_inc  = ptr_inc(r_wp);
    assign rp_inc  = ptr_inc(r_rp);
    assign empty   = (r_wp == r_rp);
    assign is_bulk = (i_item.operation == OP_BULK);
    assign is_pop  = (i_item.operation == OP_POP);
    assign is_look = is_pop || (i_item.operation == OP_PEEK);
    assign wr_en   = i_fire && is_bulk && (wp_inc != r_rp);
    assign head    = r_byp ? r_byp_data : r_mem_q;

    // head always holds the entry at r_rp (bypass covers write-then-read)
    assign n_wp = wr_en ? wp_inc : r_wp;
    assign n_rp = (i_fire && is_pop && !empty) ? rp_inc : r_rp;

    always_comb begin
        o_res = '0;
        if (is_bulk) begin
            o_res.accepted = 1'b1;
            o_res.halt_rx  = i_item.last_in_packet && (n_wp != r_rp) &&
                             (ring_dist(r_rp, n_wp) < PTR_W'(HIGH_MARK));
        end else if (is_look && !empty) begin
            o_res.accepted   = 1'b1;
            o_res.read_valid = 1'b1;
            o_res.read_byte  = head;
            if (is_pop) begin
                o_res.resume_rx = (r_wp == rp_inc) ||
                                  (ring_dist(rp_inc, r_wp) >= PTR_W'(HIGH_MARK));
            end
        end
        o_res.fill_count = 8'(ring_dist(n_wp, n_rp));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wp] <= i_item.data_byte;
        end
        r_mem_q    <= mem[n_rp];
        r_byp_data <= i_item.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_byp <= 1'b0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_byp <= wr_en && (r_wp == n_rp);
        end
    end

endmodule

@@ src/cdc_acm_control_and_rx_fifo.sv @@
// cdc_acm_control_and_rx_fifo: top level of the CDC ACM function-side block.
// Depends on acm_pkg, acm_ctrl and acm_rxfifo.
//
//   Channel   Direction  Handshake                 Payload
//   in        sink       i_in_valid / o_in_ready   i_in_data  (t_in_item)
//   out       source     o_out_valid / i_out_ready o_out_data (t_out_item)
//   apb cfg   slave      psel/penable/pready       control_interface at 0x0
//
// One transfer in, one transfer out. An item passes the input register,
// then one pass of decode and pointer logic into the output register.
// Throughput is one item per cycle while the output is not stalled; the
// buffer's single write and single registered read per cycle set that figure.
// A stalled output holds the pipeline; the input register still takes one
// transfer while the output waits. Reset is synchronous, active low, and
// clears pointers, line coding and the pending flag; buffer contents are
// not cleared.

module cdc_acm_control_and_rx_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  acm_pkg::t_in_item             i_in_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output acm_pkg::t_out_item            o_out_data,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acm_pkg::APB_AW-1:0]    paddr,
    input  logic [acm_pkg::APB_DW-1:0]    pwdata,
    output logic [acm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import acm_pkg::*;

    // input stage
    logic      r_in_valid;
    t_in_item  r_in;
    // output stage
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    // config
    logic [CTRL_IF_W-1:0] r_ctrl_if;

    logic      fire;
    logic      reg_hit;
    t_ctrl_res ctrl_res;
    t_fifo_res fifo_res;

    // Process the held item when the output register is free or draining.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // APB: one register, byte offset ignored
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1] == REG_CTRL_IF_WD);
    assign prdata  = reg_hit ? APB_DW'(r_ctrl_if) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_if <= '0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_ctrl_if <= pwdata[CTRL_IF_W-1:0];
        end
    end

    acm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in),
        .i_ctrl_if (r_ctrl_if),
        .o_res     (ctrl_res)
    );

    acm_rxfifo u_rxfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (fifo_res)
    );

    // Accepted is ORed; other fields each come from the side that owns them.
    always_comb begin
        n_out                   = '0;
        n_out.accepted          = ctrl_res.accepted | fifo_res.accepted;
        n_out.reply_kind        = ctrl_res.reply_kind;
        n_out.reply_rate        = ctrl_res.reply_rate;
        n_out.reply_char_format = ctrl_res.reply_char_format;
        n_out.reply_parity      = ctrl_res.reply_parity;
        n_out.reply_data_bits   = ctrl_res.reply_data_bits;
        n_out.enter_bootloader  = ctrl_res.enter_bootloader;
        n_out.read_byte         = fifo_res.read_byte;
        n_out.read_valid        = fifo_res.read_valid;
        n_out.halt_rx           = fifo_res.halt_rx;
        n_out.resume_rx         = fifo_res.resume_rx;
        n_out.fill_count        = fifo_res.fill_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/acm_checker.sv @@
// acm_checker: port-level assertions for cdc_acm_control_and_rx_fifo,
// bound to the top level. Depends on acm_pkg.

module acm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  acm_pkg::t_out_item o_out_data
);
    import acm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_read_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.read_valid |-> o_out_data.accepted)
        else $error("read without accepted");

    a_reply_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.reply_kind == REPLY_STATUS ||
                        o_out_data.reply_kind == REPLY_CODING)
        |-> o_out_data.accepted && !o_out_data.read_valid)
        else $error("reply without accepted or with read data");

    a_flow_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.halt_rx && o_out_data.resume_rx))
        else $error("halt and resume together");

    a_coding_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.reply_kind != REPLY_CODING
        |-> o_out_data.reply_rate == 32'd0 && o_out_data.reply_data_bits == 8'd0)
        else $error("coding fields set outside coding reply");

endmodule

bind cdc_acm_control_and_rx_fifo acm_checker u_acm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ dv/acm_result_checker.sv @@
// acm_result_checker: watches the item, result and APB channels of the CDC ACM
// block, predicts every result and compares it field by field.
// Depends on acm_pkg.
`timescale 1ns / 100ps

module acm_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  acm_pkg::t_in_item           i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  acm_pkg::t_out_item          i_out_data,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [acm_pkg::APB_AW-1:0]  i_paddr,
    input  logic [acm_pkg::APB_DW-1:0]  i_pwdata,
    output int                          o_expected_count,
    output int                          o_fail_count
);
    import acm_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_CTRL_IF = APB_AW'(4 * REG_CTRL_IF_WD);
    localparam int PRINT_CAP = 100;

    // shadow of the block state
    logic [7:0]           rx_mem [BUFFER_DEPTH];
    logic [PTR_W-1:0]     wr_ptr;
    logic [PTR_W-1:0]     rd_ptr;
    logic [31:0]          line_rate;
    logic [7:0]           stop_bits;
    logic [7:0]           parity_type;
    logic [7:0]           data_bits;
    logic [7:0]           ctl_lines;
    logic                 coding_armed;
    logic [CTRL_IF_W-1:0] ctrl_if;

    t_out_item pending_results[$];
    int        results_seen;

    initial begin
        o_expected_count = 0;
        o_fail_count     = 0;
        results_seen     = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // ring distance from write pointer to read pointer, same rule as the halt/resume tests
    function automatic int space_left();
        return (int'(rd_ptr) + BUFFER_DEPTH - int'(wr_ptr)) % BUFFER_DEPTH;
    endfunction

    task automatic predict_acm(input t_in_item it, output t_out_item res);
        logic [15:0] sig;
        int          next_wr;
        res = '0;
        sig = {it.request_type, it.request_code};
        case (it.operation)
            OP_SETUP: begin
                if (it.index_low == 8'(ctrl_if)) begin
                    if (sig == SIG_SET_CODING) begin
                        coding_armed = 1'b1;
                        res.accepted = 1'b1;
                    end else if (sig == SIG_SET_STATE) begin
                        ctl_lines            = it.value_low;
                        res.enter_bootloader = (ctl_lines == 8'h00) && (line_rate == TOUCH_BAUD);
                        res.accepted         = 1'b1;
                        res.reply_kind       = REPLY_STATUS;
                    end else if (sig == SIG_GET_CODING) begin
                        res.accepted          = 1'b1;
                        res.reply_kind        = REPLY_CODING;
                        res.reply_rate        = line_rate;
                        res.reply_char_format = stop_bits;
                        res.reply_parity      = parity_type;
                        res.reply_data_bits   = data_bits;
                    end
                end
            end
            OP_CDATA: begin
                if (it.target == 8'(ctrl_if) && coding_armed) begin
                    res.enter_bootloader = (it.rate == '0) && (line_rate == TOUCH_BAUD);
                    line_rate      = it.rate;
                    stop_bits      = it.char_format;
                    parity_type    = it.parity_code;
                    data_bits      = it.data_bit_count;
                    res.accepted   = 1'b1;
                    res.reply_kind = REPLY_STATUS;
                end
            end
            OP_BULK: begin
                // one slot always stays free; a byte into a full ring is lost
                next_wr = (int'(wr_ptr) + 1) % BUFFER_DEPTH;
                if (next_wr != int'(rd_ptr)) begin
                    rx_mem[wr_ptr] = it.data_byte;
                    wr_ptr         = PTR_W'(next_wr);
                end
                res.halt_rx  = it.last_in_packet && (space_left() < HIGH_MARK)
                               && (wr_ptr != rd_ptr);
                res.accepted = 1'b1;
            end
            OP_POP, OP_PEEK: begin
                if (wr_ptr != rd_ptr) begin
                    res.read_byte  = rx_mem[rd_ptr];
                    res.read_valid = 1'b1;
                    res.accepted   = 1'b1;
                    if (it.operation == OP_POP) begin
                        rd_ptr        = PTR_W'((int'(rd_ptr) + 1) % BUFFER_DEPTH);
                        res.resume_rx = (space_left() >= HIGH_MARK) || (wr_ptr == rd_ptr);
                    end
                end
            end
            default: ;
        endcase
        res.fill_count = 8'((int'(wr_ptr) + BUFFER_DEPTH - int'(rd_ptr)) % BUFFER_DEPTH);
    endtask

    task automatic compare_result(input t_out_item got, input t_out_item want);
        check_field("accepted",          got.accepted,          want.accepted);
        check_field("reply_kind",        got.reply_kind,        want.reply_kind);
        check_field("reply_rate",        got.reply_rate,        want.reply_rate);
        check_field("reply_char_format", got.reply_char_format, want.reply_char_format);
        check_field("reply_parity",      got.reply_parity,      want.reply_parity);
        check_field("reply_data_bits",   got.reply_data_bits,   want.reply_data_bits);
        check_field("read_byte",         got.read_byte,         want.read_byte);
        check_field("read_valid",        got.read_valid,        want.read_valid);
        check_field("halt_rx",           got.halt_rx,           want.halt_rx);
        check_field("resume_rx",         got.resume_rx,         want.resume_rx);
        check_field("enter_bootloader",  got.enter_bootloader,  want.enter_bootloader);
        check_field("fill_count",        got.fill_count,        want.fill_count);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item res;
        if (!i_rst_n) begin
            wr_ptr       = '0;
            rd_ptr       = '0;
            line_rate    = '0;
            stop_bits    = '0;
            parity_type  = '0;
            data_bits    = '0;
            ctl_lines    = '0;
            coding_armed = 1'b0;
            ctrl_if      = '0;
            pending_results.delete();
        end else begin
            // result transfer first: the output is registered, so a result
            // never belongs to an item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want = pending_results.pop_front();
                    compare_result(i_out_data, want);
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                predict_acm(i_in_data, res);
                pending_results.push_back(res);
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_CTRL_IF)
                ctrl_if = i_pwdata[CTRL_IF_W-1:0];
        end
        o_expected_count = pending_results.size();
    end

endmodule

@@ dv/testbench.sv @@
// testbench: stimulus and verdict for cdc_acm_control_and_rx_fifo. Drives the
// item, result and APB ports; acm_result_checker does the prediction.
// Depends on acm_pkg, the block's RTL and dv/acm_result_checker.sv.
`timescale 1ns / 100ps

module testbench;
    import acm_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_CTRL_IF  = APB_AW'(4 * REG_CTRL_IF_WD);
    localparam logic [15:0]       SIG_UNKNOWN   = 16'h2121;  // right type, no such request
    localparam int                OP_CODES      = 8;         // 3-bit operation field
    localparam int                SETTLE_CYCLES = 4;
    localparam int                DRAIN_CYCLES  = 8;
    localparam int                STALL_LIMIT   = 1000;      // cycles with no transfer at all

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int expected_count;
    int fail_count;

    // stimulus steering
    logic [CTRL_IF_W-1:0] cur_if    = '0;  // interface the block answers to now
    bit                   calm      = 1'b0; // no idling on either side
    bit                   fill_mode = 1'b1; // favor bulk packets over reads
    int                   backlog   = 0;    // rough byte count in the ring, steering only
    int                   sent      = 0;    // items that do something
    int                   quiet_cycles = 0;

    always #5 clk = ~clk;

    cdc_acm_control_and_rx_fifo u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    acm_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_data       (out_data),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_expected_count (expected_count),
        .o_fail_count     (fail_count)
    );

    // Watchdog: any transfer on any channel restarts the count. Longest
    // legal quiet stretch is a random stall or gap plus the settle before a
    // register write, far below the limit.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: ready mostly high, dropped now and then in random bursts.
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    //------------------------------------------------------------------
    // Item builders. Fields that the operation ignores get random
    // values so every bit of the payload toggles.
    //------------------------------------------------------------------
    function automatic t_in_item noise_item();
        t_in_item it;
        it.operation      = 3'($urandom_range(0, OP_CODES - 1));
        it.request_type   = 8'($urandom);
        it.request_code   = 8'($urandom);
        it.value_low      = 8'($urandom);
        it.index_low      = 8'($urandom);
        it.target         = 8'($urandom);
        it.rate           = $urandom;
        it.char_format    = 8'($urandom);
        it.parity_code    = 8'($urandom);
        it.data_bit_count = 8'($urandom);
        it.data_byte      = 8'($urandom);
        it.last_in_packet = 1'($urandom);
        return it;
    endfunction

    function automatic t_in_item setup_req(input logic [15:0] sig, input logic [7:0] lines,
                                           input logic [7:0] ifc);
        t_in_item it;
        it           = noise_item();
        it.operation = OP_SETUP;
        {it.request_type, it.request_code} = sig;
        it.value_low = lines;
        it.index_low = ifc;
        return it;
    endfunction

    function automatic t_in_item coding_data(input logic [7:0] ifc, input logic [31:0] baud,
                                             input logic [7:0] stop, input logic [7:0] parity,
                                             input logic [7:0] bits);
        t_in_item it;
        it                = noise_item();
        it.operation      = OP_CDATA;
        it.target         = ifc;
        it.rate           = baud;
        it.char_format    = stop;
        it.parity_code    = parity;
        it.data_bit_count = bits;
        return it;
    endfunction

    function automatic t_in_item bulk_byte(input logic [7:0] b, input logic last);
        t_in_item it;
        it                = noise_item();
        it.operation      = OP_BULK;
        it.data_byte      = b;
        it.last_in_packet = last;
        return it;
    endfunction

    function automatic t_in_item read_req(input logic [2:0] op);
        t_in_item it;
        it           = noise_item();
        it.operation = op;
        return it;
    endfunction

    // interface number for a request: mostly ours, sometimes anything
    function automatic logic [7:0] addressed();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(cur_if);
    endfunction

    //------------------------------------------------------------------
    // Item side. Called at a rising edge; returns at the edge where the
    // transfer happens, with valid still high so the next item follows
    // back to back unless a gap is drawn.
    //------------------------------------------------------------------
    task automatic push_item(input t_in_item it);
        if (!calm && $urandom_range(0, 11) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        if (it.operation <= OP_PEEK)
            sent++;
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register writes only with the block idle: every item yields a result,
    // so an empty expectation queue plus the SETTLE_CYCLES wait means nothing in flight.
    task automatic reconfigure(input logic [CTRL_IF_W-1:0] ifc);
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(ADDR_CTRL_IF, APB_DW'(ifc));
        cur_if = ifc;
    endtask

    // Random traffic. Mostly well-formed: line coding exchanges, line state
    // changes, whole bulk packets and read bursts; a little pure noise.
    // backlog flips fill_mode so the ring runs full (drops, halts) and then
    // drains to empty (resumes, empty reads) over and over.
    task automatic run_phase(input int quota);
        int          start;
        int          pick;
        int          n;
        int          k;
        int          pops;
        logic [31:0] baud;
        logic [2:0]  op;
        t_in_item    it;
        start = sent;
        while (sent - start < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // Set Line Coding, its data stage, often read back
                push_item(setup_req(SIG_SET_CODING, 8'($urandom), addressed()));
                k    = $urandom_range(0, 9);
                baud = (k < 3) ? TOUCH_BAUD : (k < 5) ? 32'd0 : $urandom;
                push_item(coding_data(addressed(), baud, 8'($urandom), 8'($urandom),
                                      8'($urandom)));
                if ($urandom_range(0, 1) == 0)
                    push_item(setup_req(SIG_GET_CODING, 8'($urandom), addressed()));
            end else if (pick < 18) begin
                // line state; zero often, to hit the bootloader touch
                push_item(setup_req(SIG_SET_STATE,
                                    ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom),
                                    addressed()));
                if ($urandom_range(0, 2) == 0)
                    push_item(setup_req(SIG_GET_CODING, 8'($urandom), addressed()));
            end else if (pick < (fill_mode ? 80 : 30)) begin
                n = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 40);
                for (k = 0; k < n; k++)
                    push_item(bulk_byte(8'($urandom), k == n - 1));
                backlog += n;
            end else if (pick < 94) begin
                n    = $urandom_range(1, fill_mode ? 6 : 40);
                pops = 0;
                for (k = 0; k < n; k++) begin
                    op = ($urandom_range(0, 4) == 0) ? OP_PEEK : OP_POP;
                    push_item(read_req(op));
                    if (op == OP_POP)
                        pops++;
                end
                backlog = (backlog > pops) ? backlog - pops : 0;
            end else begin
                it = noise_item();
                if ($urandom_range(0, 1) == 0) begin
                    it.index_low = 8'(cur_if);
                    it.target    = 8'(cur_if);
                end
                push_item(it);
            end
            if (fill_mode && backlog >= BUFFER_DEPTH + 40)
                fill_mode = 1'b0;
            else if (!fill_mode && backlog == 0)
                fill_mode = 1'b1;
        end
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin : main
        int op;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, interface 0 from reset.
        push_item(read_req(OP_PEEK));                              // empty peek
        push_item(read_req(OP_POP));                               // empty pop
        push_item(setup_req(SIG_GET_CODING, 8'h00, 8'h00));        // coding at reset
        push_item(coding_data(8'h00, 32'd115200, 8'h00, 8'h00, 8'h08)); // data, not armed
        push_item(setup_req(SIG_SET_CODING, 8'h00, 8'hFF));        // wrong interface
        push_item(setup_req(SIG_UNKNOWN, 8'h00, 8'h00));           // unknown request
        push_item(setup_req(SIG_SET_CODING, 8'h00, 8'h00));        // arm
        push_item(coding_data(8'h01, 32'd9600, 8'h00, 8'h00, 8'h08)); // wrong target
        push_item(coding_data(8'h00, TOUCH_BAUD, 8'h00, 8'h00, 8'h08));
        push_item(setup_req(SIG_SET_STATE, 8'h00, 8'h00));         // touch then lines low
        push_item(coding_data(8'h00, 32'd0, 8'h00, 8'h00, 8'h08)); // touch then zero rate
        push_item(coding_data(8'h00, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
        push_item(setup_req(SIG_GET_CODING, 8'hFF, 8'h00));
        push_item(setup_req(SIG_SET_STATE, 8'hFF, 8'h00));
        for (op = int'(OP_PEEK) + 1; op < OP_CODES; op++)           // unused opcodes
            push_item(read_req(3'(op)));
        push_item(bulk_byte(8'h00, 1'b0));
        push_item(bulk_byte(8'hFF, 1'b1));
        push_item(read_req(OP_PEEK));
        push_item(read_req(OP_POP));
        push_item(read_req(OP_POP));                               // drains to empty
        push_item(setup_req(SIG_SET_STATE, 8'h00, 8'h00));         // lines low, no touch

        // Random part over several interface settings, extremes included.
        reconfigure(CTRL_IF_W'((1 << CTRL_IF_W) - 1));
        run_phase(500);
        reconfigure(CTRL_IF_W'($urandom_range(1, (1 << CTRL_IF_W) - 2)));
        run_phase(500);
        reconfigure('0);
        run_phase(500);
        calm = 1'b1;          // last stretch runs with no idling
        run_phase(350);

        // Wait out every result, then wait DRAIN_CYCLES for stray output.
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_count != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
